FILE: hw/rtl/efpr_pkg.sv
// ----------------------------------------------------------------------------
// efpr_pkg: shared constants for the envelope follower
// Register indexes, field widths and fixed-point limits.
// ----------------------------------------------------------------------------
package efpr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned EnvOutW = 16;
  localparam int unsigned HopW    = 7;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Envelope level and drive, Q.16, range 0..131071
  localparam int unsigned LevelW = 17;
  localparam logic [LevelW-1:0] LevelMax = 17'h1FFFF;

  localparam int unsigned DefaultMaxHop = 64;
  localparam logic [HopW-1:0] HopReset = 7'd64;

  localparam logic [CfgIdxW-1:0] RegMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAttack  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRelease = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHop     = 2'd3;

  localparam logic [ModeW-1:0] ModePeak = 2'd0;
  localparam logic [ModeW-1:0] ModeMs   = 2'd1;

endpackage

FILE: hw/rtl/envelope_follower_peak_rms.sv
// ----------------------------------------------------------------------------
// envelope_follower_peak_rms
// Attack/release envelope follower with peak, mean-square and RMS drive.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Word
// in        in   in_valid_i / in_ready_o   sample_i, block_end_i
// out       out  out_valid_o / out_ready_i envelope_o, last_o
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Sequencing: one word at a time through a small sequencer around one shared
// multiplier and one shared 20-bit subtractor. Peak word: multiply, update and
// the output handshake. Mean word that does not close a hop: square, accumulate.
// Closing word: as above, 31 + clog2(MAX_HOP) + 2 divide steps (39 at 64),
// 17 root steps in RMS mode, then multiply, update, output per result word.
// Reset clears envelope, square sum, count and coefficients; payload regs are not.
// A stalled output holds the sequencer; no input word is taken meanwhile.
// ----------------------------------------------------------------------------
module envelope_follower_peak_rms #(
  parameter int unsigned MAX_HOP = efpr_pkg::DefaultMaxHop
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [efpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [efpr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [efpr_pkg::SampleW-1:0] sample_i,
  input  logic                          block_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [efpr_pkg::EnvOutW-1:0]  envelope_o,
  output logic                          last_o
);

  localparam int unsigned LW     = efpr_pkg::LevelW;
  localparam int unsigned CntW   = $clog2(MAX_HOP + 1);
  localparam int unsigned SumW   = 31 + $clog2(MAX_HOP);
  localparam int unsigned DivW   = SumW + 2;
  localparam int unsigned SqrtSteps = 17;
  localparam int unsigned StepW  = $clog2(DivW + 1);
  localparam int unsigned SubW   = 20;
  localparam int unsigned ProdW  = 35;
  localparam int unsigned HW     = efpr_pkg::HopW;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StSqr  = 8'b0000_0010,
    StAcc  = 8'b0000_0100,
    StDiv  = 8'b0000_1000,
    StSqrt = 8'b0001_0000,
    StMul  = 8'b0010_0000,
    StUpd  = 8'b0100_0000,
    StOut  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [efpr_pkg::ModeW-1:0] mode_q;
  logic [efpr_pkg::CoefW-1:0] attack_q, release_q;
  logic [HW-1:0]              hop_q;

  // datapath registers
  logic signed [efpr_pkg::SampleW-1:0] smp_q;
  logic                    blk_q;
  logic [LW-1:0]           env_q, env_d;
  logic [LW-1:0]           drive_q, drive_d;
  logic [SumW-1:0]         sum_q, sum_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         n_q, n_d;
  logic [CntW-1:0]         left_q, left_d;
  logic [DivW-1:0]         dq_q, dq_d;
  logic [CntW-1:0]         drem_q, drem_d;
  logic [33:0]             rad_q, rad_d;
  logic [SubW-1:0]         srem_q, srem_d;
  logic [LW-1:0]           root_q, root_d;
  logic [StepW-1:0]        step_q, step_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    out_valid_q, out_valid_d;
  logic [efpr_pkg::EnvOutW-1:0] out_env_q, out_env_d;
  logic                    out_last_q, out_last_d;

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  // shared subtractor
  logic [SubW-1:0] sub_a, sub_b;
  logic [SubW:0]   sub_diff;
  logic            sub_ge;

  // helpers
  logic [CntW-1:0]   hop_eff;
  logic [CntW-1:0]   cnt_new;
  logic [CntW:0]     drem_sh;
  logic [SubW-1:0]   srem_sh;
  logic [16:0]       abs_s;
  logic signed [17:0] env_diff;
  logic signed [ProdW-1:0] rnd;
  logic signed [18:0] q_rnd;
  logic signed [19:0] next_env;
  logic [LW-1:0]     next_clamped;
  logic [efpr_pkg::CoefW-1:0] coef;

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[SubW];

  // Effective hop: zero reads as one, anything above MAX_HOP as MAX_HOP.
  always_comb begin
    if (hop_q == '0) begin
      hop_eff = CntW'(1);
    end else if (hop_q > HW'(MAX_HOP)) begin
      hop_eff = CntW'(MAX_HOP);
    end else begin
      hop_eff = CntW'(hop_q);
    end
  end

  assign cnt_new  = cnt_q + CntW'(1);
  assign drem_sh  = {drem_q, dq_q[DivW-1]};
  assign srem_sh  = {srem_q[SubW-3:0], rad_q[33:32]};
  assign abs_s    = sample_i[15] ? (17'd0 - {sample_i[15], sample_i}) : {1'b0, sample_i};
  assign env_diff = signed'({1'b0, env_q}) - signed'({1'b0, drive_q});
  assign coef     = (drive_q > env_q) ? attack_q : release_q;
  // Round the Q.32 product to Q.16: add half, floor.
  assign rnd      = prod_q + ProdW'(32768);
  assign q_rnd    = rnd[ProdW-1:16];
  assign next_env = signed'({3'b000, drive_q}) + 20'(q_rnd);

  always_comb begin
    if (next_env < 0) begin
      next_clamped = '0;
    end else if (next_env > signed'({3'b000, efpr_pkg::LevelMax})) begin
      next_clamped = efpr_pkg::LevelMax;
    end else begin
      next_clamped = next_env[LW-1:0];
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a = signed'({1'b0, coef});
    mul_b = env_diff;
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      StSqr: begin
        mul_a = 17'(smp_q);
        mul_b = 18'(smp_q);
      end
      StDiv: begin
        sub_a = SubW'(drem_sh);
        sub_b = SubW'(n_q);
      end
      StSqrt: begin
        sub_a = srem_sh;
        sub_b = SubW'({root_q, 2'b01});
      end
      default: mul_b = env_diff;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    env_d       = env_q;
    drive_d     = drive_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    left_d      = left_q;
    dq_d        = dq_q;
    drem_d      = drem_q;
    rad_d       = rad_q;
    srem_d      = srem_q;
    root_d      = root_q;
    step_d      = step_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_env_d   = out_env_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (mode_q == efpr_pkg::ModePeak) begin
            state_d = StMul;
            left_d  = CntW'(1);
          end else begin
            state_d = StSqr;
          end
        end
      end
      StSqr: begin
        prod_d  = ProdW'(mul_a * mul_b);
        state_d = StAcc;
      end
      StAcc: begin
        // Fold in the square, close the hop on a full count or block end.
        if (cnt_new < hop_eff && !blk_q) begin
          sum_d   = sum_q + SumW'(prod_q[30:0]);
          cnt_d   = cnt_new;
          state_d = StIdle;
        end else begin
          dq_d    = {sum_q + SumW'(prod_q[30:0]), 2'b00};
          n_d     = cnt_new;
          left_d  = cnt_new;
          sum_d   = '0;
          cnt_d   = '0;
          drem_d  = '0;
          step_d  = StepW'(DivW - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        // One quotient bit a cycle, restoring.
        if (sub_ge) begin
          drem_d = sub_diff[CntW-1:0];
          dq_d   = {dq_q[DivW-2:0], 1'b1};
        end else begin
          drem_d = drem_sh[CntW-1:0];
          dq_d   = {dq_q[DivW-2:0], 1'b0};
        end
        if (step_q == '0) begin
          if (mode_q == efpr_pkg::ModeMs) begin
            drive_d = dq_d[32:16];
            state_d = StMul;
          end else begin
            rad_d   = {1'b0, dq_d[32:0]};
            srem_d  = '0;
            root_d  = '0;
            step_d  = StepW'(SqrtSteps - 1);
            state_d = StSqrt;
          end
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      StSqrt: begin
        // One root bit a cycle, two radicand bits in.
        rad_d = {rad_q[31:0], 2'b00};
        if (sub_ge) begin
          srem_d = sub_diff[SubW-1:0];
          root_d = {root_q[LW-2:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[LW-2:0], 1'b0};
        end
        if (step_q == '0) begin
          drive_d = root_d;
          state_d = StMul;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      StMul: begin
        prod_d  = ProdW'(mul_a * mul_b);
        state_d = StUpd;
      end
      StUpd: begin
        env_d       = next_clamped;
        out_env_d   = next_clamped[LW-1] ? '1 : next_clamped[efpr_pkg::EnvOutW-1:0];
        out_last_d  = (left_q == CntW'(1));
        out_valid_d = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          left_d      = left_q - CntW'(1);
          state_d     = (left_q == CntW'(1)) ? StIdle : StMul;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= efpr_pkg::ModePeak;
      attack_q    <= '0;
      release_q   <= '0;
      hop_q       <= efpr_pkg::HopReset;
      env_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          efpr_pkg::RegMode:    mode_q    <= cfg_data_i[efpr_pkg::ModeW-1:0];
          efpr_pkg::RegAttack:  attack_q  <= cfg_data_i;
          efpr_pkg::RegRelease: release_q <= cfg_data_i;
          efpr_pkg::RegHop:     hop_q     <= cfg_data_i[HW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      smp_q <= sample_i;
      blk_q <= block_end_i;
    end
    if (state_q == StIdle) begin
      drive_q <= {abs_s[15:0], 1'b0};
    end else begin
      drive_q <= drive_d;
    end
    n_q       <= n_d;
    dq_q      <= dq_d;
    drem_q    <= drem_d;
    rad_q     <= rad_d;
    srem_q    <= srem_d;
    root_q    <= root_d;
    prod_q    <= prod_d;
    out_env_q <= out_env_d;
    out_last_q <= out_last_d;
  end

  // Peak drive loads straight from the input word while idle.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign envelope_o  = out_env_q;
  assign last_o      = out_last_q;

  // Checks
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == StOut))
    else $error("output word valid outside output state");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (state_q == StIdle))
    else $error("sequencer did not return to idle after last word");

endmodule
